// ===== hdl/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Motor run sequencer package
// Payload structs, configuration struct and the codes of mode, command,
// drive and bridge shared by the sequencer modules.
// ----------------------------------------------------------------------------
package mrs_pkg;

    // Mode codes
    localparam logic [2:0] MODE_STOPPED   = 3'd0;
    localparam logic [2:0] MODE_BOOTSTRAP = 3'd1;
    localparam logic [2:0] MODE_CHARGING  = 3'd2;
    localparam logic [2:0] MODE_READY     = 3'd3;
    localparam logic [2:0] MODE_RUNNING   = 3'd4;
    localparam logic [2:0] MODE_FAULT     = 3'd5;

    // Command codes (the spare code means nothing)
    localparam logic [1:0] CMD_NONE  = 2'd0;
    localparam logic [1:0] CMD_GO    = 2'd1;
    localparam logic [1:0] CMD_HALT  = 2'd2;
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Drive request codes
    localparam logic [1:0] DRV_NONE    = 2'd0;
    localparam logic [1:0] DRV_DISABLE = 2'd1;
    localparam logic [1:0] DRV_ENABLE  = 2'd2;

    // Bridge request codes
    localparam logic [1:0] BRG_NONE      = 2'd0;
    localparam logic [1:0] BRG_PRECHARGE = 2'd1;
    localparam logic [1:0] BRG_ALL_OFF   = 2'd2;

    // Register map: one 32-bit word per register, selected by paddr[2]
    localparam int         PADDR_W         = 3;
    localparam logic       REG_CHARGE      = 1'b0;
    localparam logic       REG_READY_TMO   = 1'b1;
    localparam logic [15:0] CHARGE_RESET   = 16'd50;
    localparam logic [15:0] READY_TMO_RESET = 16'd30000;

    typedef struct packed {
        logic [1:0] command;
        logic       fault_active;
        logic       knob_nonzero;
        logic       ramp_at_zero;
    } t_in;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] drive_request;
        logic       force_duty_zero;
        logic [1:0] bridge_request;
        logic       ramp_step;
        logic       hall_timer_clear;
    } t_out;

    typedef struct packed {
        logic [15:0] charge_ticks;
        logic [15:0] ready_timeout_ticks;
    } t_cfg;

endpackage

// ===== hdl/motor_run_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// Motor run sequencer top level
// Input register, sequencer core, result register and configuration port.
// ----------------------------------------------------------------------------
// One tick beat in gives one result beat out, passing through the input
// register and then the result register. The input register hands the tick
// to the core, whose transition logic updates the mode and counters and loads
// the result register in the same cycle, so the rate is one tick per clock
// unless stalled, set only by the single register-to-register pass through
// the core. Both stages stall only while the result register is full and not
// taken. Charge time and ready timeout sit at byte addresses 0 and 4 and may
// be changed only while no tick is in flight.
module motor_run_sequencer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  mrs_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output mrs_pkg::t_out               o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    mrs_pkg::t_cfg w_cfg;
    mrs_pkg::t_out w_res;
    mrs_pkg::t_in  r_in;
    mrs_pkg::t_out r_out;
    logic          r_in_valid;
    logic          r_out_valid;
    logic          w_adv;

    // Configuration registers
    mrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Move a tick to the result register when there is room
    assign w_adv      = r_in_valid & (~r_out_valid | i_out_ready);
    assign o_in_ready = ~r_in_valid | w_adv;

    mrs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_tick  (r_in),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A present fault always yields the fault mode
    a_fault_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv && r_in.fault_active |=> r_out.mode == mrs_pkg::MODE_FAULT)
        else $error("fault tick did not give fault mode");

    // Drive enable only on the way into running
    a_enable_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.drive_request == mrs_pkg::DRV_ENABLE
        |-> o_out.mode == mrs_pkg::MODE_RUNNING)
        else $error("drive enabled outside running");

    // Result mode is always a defined code
    a_mode_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out.mode <= mrs_pkg::MODE_FAULT)
        else $error("undefined mode in result");

    // Ramp steps only come from running or its exit to ready
    a_ramp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.ramp_step
        |-> (o_out.mode == mrs_pkg::MODE_RUNNING || o_out.mode == mrs_pkg::MODE_READY))
        else $error("ramp step outside running");

endmodule

// ===== hdl/mrs_cfg.sv =====
// ----------------------------------------------------------------------------
// Motor run sequencer configuration registers
// APB-style slave holding the charge time and the ready timeout.
// ----------------------------------------------------------------------------
module mrs_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mrs_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output mrs_pkg::t_cfg               o_cfg
);

    logic          w_wr;
    mrs_pkg::t_cfg r_cfg;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    // Write on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.charge_ticks        <= mrs_pkg::CHARGE_RESET;
            r_cfg.ready_timeout_ticks <= mrs_pkg::READY_TMO_RESET;
        end else if (w_wr) begin
            unique case (paddr[2])
                mrs_pkg::REG_CHARGE:    r_cfg.charge_ticks        <= pwdata[15:0];
                mrs_pkg::REG_READY_TMO: r_cfg.ready_timeout_ticks <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            mrs_pkg::REG_CHARGE:    prdata = {16'd0, r_cfg.charge_ticks};
            mrs_pkg::REG_READY_TMO: prdata = {16'd0, r_cfg.ready_timeout_ticks};
            default:                prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/mrs_core.sv =====
// ----------------------------------------------------------------------------
// Motor run sequencer core
// Mode register, tick counters and the per-tick transition and action logic.
// ----------------------------------------------------------------------------
module mrs_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  mrs_pkg::t_in  i_tick,
    input  mrs_pkg::t_cfg i_cfg,
    output mrs_pkg::t_out o_res
);

    logic [2:0]  r_mode;
    logic [2:0]  n_mode;
    logic [15:0] r_charge_cnt;
    logic [15:0] n_charge_cnt;
    logic [15:0] r_ready_cnt;
    logic [15:0] n_ready_cnt;
    logic [2:0]  w_mode_eff;
    logic [15:0] w_charge_inc;
    logic [15:0] w_ready_inc;

    // Saturating increments
    assign w_charge_inc = (r_charge_cnt == 16'hFFFF) ? r_charge_cnt : r_charge_cnt + 16'd1;
    assign w_ready_inc  = (r_ready_cnt == 16'hFFFF) ? r_ready_cnt : r_ready_cnt + 16'd1;

    // Fault overrides, then stop
    always_comb begin
        if (i_tick.fault_active) begin
            w_mode_eff = mrs_pkg::MODE_FAULT;
        end else if (i_tick.command == mrs_pkg::CMD_HALT) begin
            w_mode_eff = mrs_pkg::MODE_STOPPED;
        end else begin
            w_mode_eff = r_mode;
        end
    end

    // Run the action of the mode
    always_comb begin
        n_mode       = w_mode_eff;
        n_charge_cnt = r_charge_cnt;
        n_ready_cnt  = r_ready_cnt;
        o_res        = '0;
        unique case (w_mode_eff)
            mrs_pkg::MODE_FAULT: begin
                o_res.drive_request   = mrs_pkg::DRV_DISABLE;
                o_res.force_duty_zero = ~i_tick.ramp_at_zero;
                if (!i_tick.fault_active) begin
                    n_mode = mrs_pkg::MODE_STOPPED;
                end
            end
            mrs_pkg::MODE_BOOTSTRAP: begin
                o_res.bridge_request = mrs_pkg::BRG_PRECHARGE;
                n_charge_cnt         = 16'd0;
                n_mode               = mrs_pkg::MODE_CHARGING;
            end
            mrs_pkg::MODE_CHARGING: begin
                n_charge_cnt = w_charge_inc;
                if (w_charge_inc >= i_cfg.charge_ticks) begin
                    o_res.bridge_request = mrs_pkg::BRG_ALL_OFF;
                    n_ready_cnt          = 16'd0;
                    n_mode               = mrs_pkg::MODE_READY;
                end
            end
            mrs_pkg::MODE_READY: begin
                if (i_tick.knob_nonzero) begin
                    o_res.hall_timer_clear = 1'b1;
                    o_res.drive_request    = mrs_pkg::DRV_ENABLE;
                    n_mode                 = mrs_pkg::MODE_RUNNING;
                end else begin
                    n_ready_cnt = w_ready_inc;
                    if (w_ready_inc >= i_cfg.ready_timeout_ticks) begin
                        n_mode = mrs_pkg::MODE_STOPPED;
                    end
                end
            end
            mrs_pkg::MODE_RUNNING: begin
                o_res.ramp_step = 1'b1;
                if (!i_tick.knob_nonzero && i_tick.ramp_at_zero) begin
                    n_ready_cnt = 16'd0;
                    n_mode      = mrs_pkg::MODE_READY;
                end
            end
            default: begin
                // Stopped, and the unused codes that act as stopped
                o_res.drive_request   = mrs_pkg::DRV_DISABLE;
                o_res.force_duty_zero = ~i_tick.ramp_at_zero;
                if (i_tick.command == mrs_pkg::CMD_GO) begin
                    n_mode = mrs_pkg::MODE_BOOTSTRAP;
                end else begin
                    n_mode = mrs_pkg::MODE_STOPPED;
                end
            end
        endcase
        o_res.mode = n_mode;
    end

    // Advance state once per tick beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= mrs_pkg::MODE_STOPPED;
            r_charge_cnt <= 16'd0;
            r_ready_cnt  <= 16'd0;
        end else if (i_en) begin
            r_mode       <= n_mode;
            r_charge_cnt <= n_charge_cnt;
            r_ready_cnt  <= n_ready_cnt;
        end
    end

endmodule
